// File: rtl/ptr_pkg.sv
// Shared types and constants of the page table translation block.
// Used by the channel interfaces and by the top level; no dependencies.
package ptr_pkg;

  // Default sizes handed to the top level as parameter defaults.
  localparam int MAX_FRAMES_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int PS_W  = 17;  // page size register
  localparam int FC_W  = 7;   // frame count write field
  localparam int PA_W  = 22;  // physical address
  localparam int CFG_W = 17;  // configuration write data
  localparam int CFG_IDX_W = 2;

  // Register reset values and the page size limit.
  localparam int PS_RESET = 1024;
  localparam int FC_RESET = 64;
  localparam int PS_MAX   = 65536;

  // Register indices of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd2;

  // Replacement modes.
  localparam logic MODE_LRU  = 1'b0;
  localparam logic MODE_FIFO = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_CMP,
    ST_MISS,
    ST_SH_RD,
    ST_SH_WR,
    ST_MUL,
    ST_OUT
  } ptr_state_t;

endpackage

// File: rtl/ptr_channels.sv
// Valid/ready channel interfaces for the address word and the result word.
// Depends on ptr_pkg for widths.
interface ptr_in_if #(
  parameter int ADDR_BITS = ptr_pkg::ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

interface ptr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      page_fault;
  logic [ptr_pkg::PA_W-1:0]  physical_address;

  modport source (output valid, output page_fault, output physical_address, input ready);
  modport sink   (input valid, input page_fault, input physical_address, output ready);
endinterface

// File: rtl/page_table_translate_replace_top.sv
// Page table translation with LRU or FIFO replacement, one sequencer and one table memory.
// Depends on ptr_pkg and the channel interfaces in ptr_channels.sv.
//
// Each address word is split into page and offset by a restoring divider that resolves one
// quotient bit a cycle. The table lives in a single memory with one read and one write
// port; the search reads one entry at a time (ST_RD, then ST_CMP) and stops at the first
// match, and a move (LRU hit or eviction when full) copies one entry at a time through
// ST_SH_RD and ST_SH_WR. A word passes from acceptance through the divide, the search, any
// move and ST_MUL (skipped on a fault) to ST_OUT, and returns to idle before the next word
// is taken. Input is refused while a word is in progress; a finished result waits in the
// output register while the next word is accepted.
// The table is cleared by a fill count, so reset and configuration writes take effect at once.
module page_table_translate_replace_top #(
  parameter int MAX_FRAMES = ptr_pkg::MAX_FRAMES_DEF,
  parameter int ADDR_BITS  = ptr_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ptr_in_if.sink                        in_chan,
  ptr_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [ptr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IDX_W   = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int ENT_W   = ADDR_BITS + IDX_W;
  localparam int REM_W   = ptr_pkg::PS_W + 1;
  localparam int DCNT_W  = $clog2(ADDR_BITS);
  localparam int PROD_W  = IDX_W + ptr_pkg::PS_W;
  localparam int N_RESET = (ptr_pkg::FC_RESET > MAX_FRAMES) ? MAX_FRAMES : ptr_pkg::FC_RESET;

  // Configuration, held as effective values.
  logic [ptr_pkg::PS_W-1:0] ps_r;
  logic [CNT_W-1:0]         n_r;
  logic                     mode_r;
  logic                     cfg_hit;

  // Sequencer state.
  ptr_pkg::ptr_state_t      state_r, state_nxt;
  logic [DCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0]     div_r, div_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;
  logic [IDX_W-1:0]         end_r, end_nxt;
  logic [IDX_W-1:0]         frame_r, frame_nxt;
  logic [IDX_W-1:0]         frame0_r, frame0_nxt;
  logic                     fault_r, fault_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_fault_r, out_fault_nxt;
  logic [ptr_pkg::PA_W-1:0] out_pa_r, out_pa_nxt;

  // Table memory.
  logic [ENT_W-1:0]         mem [MAX_FRAMES];
  logic [ENT_W-1:0]         rdata_r;
  logic                     mem_we;
  logic [IDX_W-1:0]         wr_addr;
  logic [ENT_W-1:0]         wr_data;
  logic [IDX_W-1:0]         rd_addr;

  // Divider step and table helpers.
  logic [REM_W-1:0]         trial;
  logic                     trial_ge;
  logic [ADDR_BITS-1:0]     rd_page;
  logic [IDX_W-1:0]         rd_frame;
  logic [IDX_W-1:0]         last_idx;
  logic [PROD_W:0]          pa_sum;

  assign cfg_hit  = cfg_we && (cfg_index == ptr_pkg::CFG_PAGE_SIZE ||
                               cfg_index == ptr_pkg::CFG_FRAME_COUNT ||
                               cfg_index == ptr_pkg::CFG_MODE);
  assign trial    = {rem_r[REM_W-2:0], div_r[ADDR_BITS-1]};
  assign trial_ge = trial >= REM_W'(ps_r);
  assign rd_page  = rdata_r[ENT_W-1:IDX_W];
  assign rd_frame = rdata_r[IDX_W-1:0];
  assign last_idx = IDX_W'(fill_r - 1'b1);
  assign pa_sum   = (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(rem_r);

  assign in_chan.ready             = (state_r == ptr_pkg::ST_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.page_fault       = out_fault_r;
  assign out_chan.physical_address = out_pa_r;

  // Config registers; out-of-range values fold to their limits; frame count uses low 7 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= ptr_pkg::PS_W'(ptr_pkg::PS_RESET);
      n_r    <= CNT_W'(N_RESET);
      mode_r <= ptr_pkg::MODE_LRU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptr_pkg::CFG_PAGE_SIZE: begin
          if (cfg_data == '0) begin
            ps_r <= ptr_pkg::PS_W'(1);
          end else if (cfg_data > ptr_pkg::CFG_W'(ptr_pkg::PS_MAX)) begin
            ps_r <= ptr_pkg::PS_W'(ptr_pkg::PS_MAX);
          end else begin
            ps_r <= cfg_data[ptr_pkg::PS_W-1:0];
          end
        end
        ptr_pkg::CFG_FRAME_COUNT: begin
          if (cfg_data[ptr_pkg::FC_W-1:0] == '0) begin
            n_r <= CNT_W'(1);
          end else if (int'(cfg_data[ptr_pkg::FC_W-1:0]) > MAX_FRAMES) begin
            n_r <= CNT_W'(MAX_FRAMES);
          end else begin
            n_r <= CNT_W'(cfg_data[ptr_pkg::FC_W-1:0]);
          end
        end
        ptr_pkg::CFG_MODE: begin
          mode_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptr_pkg::ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    ptr_r       <= ptr_nxt;
    end_r       <= end_nxt;
    frame_r     <= frame_nxt;
    frame0_r    <= frame0_nxt;
    fault_r     <= fault_nxt;
    prod_r      <= prod_nxt;
    out_fault_r <= out_fault_nxt;
    out_pa_r    <= out_pa_nxt;
  end

  // Table memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Sequencer: divide, search, update the table, then form the result word.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    frame_nxt     = frame_r;
    frame0_nxt    = frame0_r;
    fault_nxt     = fault_r;
    prod_nxt      = prod_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_fault_nxt = out_fault_r;
    out_pa_nxt    = out_pa_r;
    mem_we        = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rdata_r;
    rd_addr       = ptr_r;

    unique case (state_r)
      ptr_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          div_nxt   = in_chan.virtual_address;
          rem_nxt   = '0;
          cnt_nxt   = DCNT_W'(ADDR_BITS - 1);
          ptr_nxt   = '0;
          state_nxt = ptr_pkg::ST_DIV;
        end
      end
      ptr_pkg::ST_DIV: begin
        // One quotient bit per cycle; the quotient replaces the dividend bits.
        rem_nxt = trial_ge ? (trial - REM_W'(ps_r)) : trial;
        div_nxt = {div_r[ADDR_BITS-2:0], trial_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = (fill_r == '0) ? ptr_pkg::ST_MISS : ptr_pkg::ST_RD;
        end
      end
      ptr_pkg::ST_RD: begin
        rd_addr   = ptr_r;
        state_nxt = ptr_pkg::ST_CMP;
      end
      ptr_pkg::ST_CMP: begin
        if (ptr_r == '0) begin
          frame0_nxt = rd_frame;
        end
        if (rd_page == div_r) begin
          frame_nxt = rd_frame;
          fault_nxt = 1'b0;
          if (mode_r == ptr_pkg::MODE_LRU) begin
            end_nxt   = last_idx;
            state_nxt = ptr_pkg::ST_SH_RD;
          end else begin
            state_nxt = ptr_pkg::ST_MUL;
          end
        end else if (ptr_r == last_idx) begin
          state_nxt = ptr_pkg::ST_MISS;
        end else begin
          ptr_nxt   = IDX_W'(ptr_r + 1'b1);
          state_nxt = ptr_pkg::ST_RD;
        end
      end
      ptr_pkg::ST_MISS: begin
        fault_nxt = 1'b1;
        if (fill_r == n_r) begin
          // Full: evict the front entry and reuse its frame at the back.
          ptr_nxt   = '0;
          end_nxt   = last_idx;
          frame_nxt = frame0_r;
          state_nxt = ptr_pkg::ST_SH_RD;
        end else begin
          // Free entry: take it with its own frame.
          mem_we    = 1'b1;
          wr_addr   = IDX_W'(fill_r);
          wr_data   = {div_r, IDX_W'(fill_r)};
          fill_nxt  = fill_r + 1'b1;
          state_nxt = ptr_pkg::ST_OUT;
        end
      end
      ptr_pkg::ST_SH_RD: begin
        if (ptr_r == end_r) begin
          mem_we    = 1'b1;
          wr_addr   = ptr_r;
          wr_data   = {div_r, frame_r};
          state_nxt = fault_r ? ptr_pkg::ST_OUT : ptr_pkg::ST_MUL;
        end else begin
          rd_addr   = IDX_W'(ptr_r + 1'b1);
          state_nxt = ptr_pkg::ST_SH_WR;
        end
      end
      ptr_pkg::ST_SH_WR: begin
        mem_we    = 1'b1;
        wr_addr   = ptr_r;
        wr_data   = rdata_r;
        ptr_nxt   = IDX_W'(ptr_r + 1'b1);
        state_nxt = ptr_pkg::ST_SH_RD;
      end
      ptr_pkg::ST_MUL: begin
        prod_nxt  = PROD_W'(frame_r) * PROD_W'(ps_r);
        state_nxt = ptr_pkg::ST_OUT;
      end
      ptr_pkg::ST_OUT: begin
        // Load the output word once the previous one has been taken.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = fault_r;
          out_pa_nxt    = fault_r ? '0 : ptr_pkg::PA_W'(pa_sum);
          state_nxt     = ptr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptr_pkg::ST_IDLE;
      end
    endcase

    // A configuration write to one of the three registers empties the table.
    if (cfg_hit) begin
      fill_nxt = '0;
    end
  end

  // The filled region never grows past the number of entries in use.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_r)
    else $error("table fill count exceeds frame count");

  // An accepted word always starts the divider.
  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == ptr_pkg::ST_DIV))
    else $error("accepted word did not start the divide");

  // Searches only read entries inside the filled region.
  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptr_pkg::ST_RD || state_r == ptr_pkg::ST_CMP) |-> (CNT_W'(ptr_r) < fill_r))
    else $error("search pointer outside filled entries");

  // A new result word appears only from the output state.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ptr_pkg::ST_OUT))
    else $error("result word loaded outside output state");

  // The table is never written while idle.
  a_idle_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptr_pkg::ST_IDLE) |-> !mem_we)
    else $error("table written while idle");

endmodule
